/* sv/fest_pkg.sv */
//------------------------------------------------------------------------------
// Flow EWMA statistics table package
// Request and result types and fixed constants of the statistics table.
//------------------------------------------------------------------------------
package fest_pkg;

	localparam int unsigned RATE_W  = 40;
	localparam int unsigned RATIO_W = 17;
	localparam int unsigned DELAY_W = 32;
	localparam int unsigned ALPHA_W = 17;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd19661;
	localparam logic [RATE_W-1:0]  RATE_MAX    = {RATE_W{1'b1}};
	localparam logic [22:0]        BITS_PER_US = 23'd8000000;

	// Register byte addresses.
	localparam logic [1:0] REG_ALPHA = 2'd0;

	typedef struct packed {
		logic [3:0]  edge_index;
		logic [1:0]  service_class;
		logic [31:0] bytes_received;
		logic [31:0] interval_us;
		logic [15:0] bursts_built;
		logic [15:0] bursts_dropped;
		logic [31:0] window_delay_us;
		logic [31:0] queue_depth_bytes;
		logic [16:0] burst_length_limit;
		logic [19:0] burst_time_limit_us;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [39:0] rate_average;
		logic [16:0] blocking_average;
		logic [31:0] delay_average_us;
	} res_t;

endpackage

/* sv/flow_ewma_statistics_table.sv */
//------------------------------------------------------------------------------
// Flow EWMA statistics table
// Per edge and service class moving averages of rate, blocking and delay.
//------------------------------------------------------------------------------
// A valid request passes through ST_MUL, ST_DIVR, ST_DIVB, ST_BL0 to ST_BL5 and
// ST_WB before done rises; an invalid one raises done on the next cycle. busy is high until done rises.
// Throughput: one request at a time, set by a 55-step restoring division for the
// rate, a 32-step one for the ratio and the blend sequence on one multiplier.
// Reset clears the control state, loads the alpha reset value and starts clearing the memories
// entry by entry, during which busy stays high. The receiver cannot stall results.
module flow_ewma_statistics_table #(
	parameter int EDGE_COUNT  = 16,
	parameter int CLASS_COUNT = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  fest_pkg::req_t  request,
	output logic            done,
	output fest_pkg::res_t  result,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [1:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import fest_pkg::*;

	localparam int ENTRIES = EDGE_COUNT * CLASS_COUNT;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MW      = RATE_W + RATIO_W + DELAY_W;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_DIVR  = 4'd3;
	localparam logic [3:0] ST_DIVB  = 4'd4;
	localparam logic [3:0] ST_BL0   = 4'd5;
	localparam logic [3:0] ST_BL1   = 4'd6;
	localparam logic [3:0] ST_BL2   = 4'd7;
	localparam logic [3:0] ST_BL3   = 4'd8;
	localparam logic [3:0] ST_BL4   = 4'd9;
	localparam logic [3:0] ST_BL5   = 4'd10;
	localparam logic [3:0] ST_WB    = 4'd11;
	localparam logic [3:0] ST_REJ   = 4'd12;

	logic [3:0]          state_q;
	logic [AW-1:0]       addr_q;
	logic [ALPHA_W-1:0]  alpha_q;
	req_t                req_q;
	logic [MW-1:0]       avg_mem [ENTRIES];
	logic [MW-1:0]       rd_q;
	logic [68:0]         aux_mem [ENTRIES];
	logic [54:0]         prod_q;
	logic [55:0]         rem_q;
	logic [54:0]         quo_q;
	logic [5:0]          cnt_q;
	logic [RATE_W-1:0]   rate_smp_q;
	logic [RATIO_W-1:0]  ratio_smp_q;
	logic [56:0]         acc_q;
	logic [RATE_W-1:0]   new_rate_q;
	logic [RATIO_W-1:0]  new_blk_q;
	logic [DELAY_W-1:0]  new_dly_q;
	logic [ALPHA_W-1:0]  a_eff;
	logic [ALPHA_W-1:0]  a_inv;
	logic                req_ok;
	logic [AW-1:0]       req_addr;
	logic [ALPHA_W-1:0]  mul_a;
	logic [RATE_W-1:0]   mul_b;
	logic [56:0]         mul_p;
	logic [55:0]         rem_sh;
	logic [33:0]         rem_diff;
	logic [RATE_W-1:0]   old_rate;
	logic [RATIO_W-1:0]  old_blk;
	logic [DELAY_W-1:0]  old_dly;

	assign a_eff  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign a_inv  = ALPHA_ONE - a_eff;
	assign req_ok = (32'(request.edge_index) < 32'(EDGE_COUNT))
		&& (32'(request.service_class) < 32'(CLASS_COUNT));
	assign req_addr = AW'(32'(request.edge_index) * 32'(CLASS_COUNT)
		+ 32'(request.service_class));
	assign busy   = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign prdata = {15'd0, alpha_q};
	assign {old_rate, old_blk, old_dly} = rd_q;

	// One shared 17 x 40 multiplier serves every blend term.
	always_comb begin
		mul_a = a_eff;
		mul_b = rate_smp_q;
		unique case (state_q)
			ST_BL1:  begin mul_a = a_inv; mul_b = old_rate; end
			ST_BL2:  begin mul_a = a_eff; mul_b = RATE_W'(ratio_smp_q); end
			ST_BL3:  begin mul_a = a_inv; mul_b = RATE_W'(old_blk); end
			ST_BL4:  begin mul_a = a_eff; mul_b = RATE_W'(req_q.window_delay_us); end
			ST_BL5:  begin mul_a = a_inv; mul_b = RATE_W'(old_dly); end
			default: begin mul_a = a_eff; mul_b = rate_smp_q; end
		endcase
		mul_p = 57'(mul_a) * 57'(mul_b);
	end

	// Restoring divider step; the divisor is the interval or the built count.
	// The shifted remainder can reach 33 bits, so the difference keeps 34.
	always_comb begin
		rem_sh   = {rem_q[54:0], quo_q[54]};
		rem_diff = {1'b0, rem_sh[32:0]} - ((state_q == ST_DIVR)
			? {2'b0, req_q.interval_us} : {18'd0, req_q.bursts_built});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			alpha_q <= ALPHA_RESET;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			if (psel && penable && pwrite && paddr == REG_ALPHA)
				alpha_q <= pwdata[ALPHA_W-1:0];
			unique case (state_q)
				ST_CLEAR: begin
					if (32'(addr_q) == ENTRIES - 1) state_q <= ST_IDLE;
					else addr_q <= addr_q + 1'b1;
				end
				ST_IDLE: begin
					if (start) begin
						addr_q  <= req_addr;
						state_q <= req_ok ? ST_MUL : ST_REJ;
					end
				end
				ST_MUL: begin
					cnt_q   <= 6'd55;
					state_q <= ST_DIVR;
				end
				ST_DIVR: begin
					if (cnt_q == 6'd0) begin
						cnt_q   <= 6'd32;
						state_q <= ST_DIVB;
					end else cnt_q <= cnt_q - 1'b1;
				end
				ST_DIVB: begin
					if (cnt_q == 6'd0) state_q <= ST_BL0;
					else cnt_q <= cnt_q - 1'b1;
				end
				ST_BL0: state_q <= ST_BL1;
				ST_BL1: state_q <= ST_BL2;
				ST_BL2: state_q <= ST_BL3;
				ST_BL3: state_q <= ST_BL4;
				ST_BL4: state_q <= ST_BL5;
				ST_BL5: state_q <= ST_WB;
				ST_WB: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_REJ: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) req_q <= request;
		rd_q <= avg_mem[addr_q];
		unique case (state_q)
			ST_MUL: begin
				// 8e6 fits 23 bits, so the product bytes * 8e6 fits 55 bits.
				prod_q <= 55'(req_q.bytes_received) * 55'(BITS_PER_US);
				rem_q  <= '0;
			end
			ST_DIVR: begin
				if (cnt_q == 6'd55) quo_q <= prod_q;
				else begin
					if (!rem_diff[33]) begin
						rem_q <= {24'd0, rem_diff[31:0]};
						quo_q <= {quo_q[53:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[53:0], 1'b0};
					end
				end
				if (cnt_q == 6'd55) rem_q <= '0;
				if (cnt_q == 6'd0) begin
					if (req_q.interval_us == 32'd0) rate_smp_q <= '0;
					else if (!rem_diff[33] ? (quo_q[53:39] != 15'd0)
						: (quo_q[53:39] != 15'd0)) rate_smp_q <= RATE_MAX;
					else rate_smp_q <= {quo_q[38:0], ~rem_diff[33]};
					rem_q <= '0;
				end
			end
			ST_DIVB: begin
				if (cnt_q == 6'd32) begin
					// The 32 steps consume the top 32 bits: dropped followed by 16 zeros.
					quo_q <= {req_q.bursts_dropped, 39'd0};
					rem_q <= '0;
				end else begin
					if (!rem_diff[33]) begin
						rem_q <= {24'd0, rem_diff[31:0]};
						quo_q <= {quo_q[53:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[53:0], 1'b0};
					end
				end
				if (cnt_q == 6'd0) begin
					if (req_q.bursts_built == 16'd0) ratio_smp_q <= '0;
					else if ({quo_q[31:0], ~rem_diff[33]} > 33'(ALPHA_ONE))
						ratio_smp_q <= ALPHA_ONE;
					else ratio_smp_q <= {quo_q[15:0], ~rem_diff[33]};
				end
			end
			ST_BL0: acc_q <= mul_p + 57'd32768;
			ST_BL1: new_rate_q <= RATE_W'((acc_q + mul_p) >> 16);
			ST_BL2: acc_q <= mul_p + 57'd32768;
			ST_BL3: new_blk_q <= RATIO_W'((acc_q + mul_p) >> 16);
			ST_BL4: acc_q <= mul_p + 57'd32768;
			ST_BL5: new_dly_q <= (req_q.window_delay_us == 32'd0) ? old_dly
				: DELAY_W'((acc_q + mul_p) >> 16);
			default: ;
		endcase
	end

	// Memory clearing, memory write-back and result register.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			avg_mem[addr_q] <= '0;
			aux_mem[addr_q] <= '0;
		end else if (state_q == ST_WB) begin
			avg_mem[addr_q] <= {new_rate_q, new_blk_q, new_dly_q};
			aux_mem[addr_q] <= {req_q.queue_depth_bytes, req_q.burst_time_limit_us,
				req_q.burst_length_limit};
		end
		if (state_q == ST_WB)
			result <= {1'b1, new_rate_q, new_blk_q, new_dly_q};
		else if (state_q == ST_REJ)
			result <= '0;
	end

endmodule

/* sv/fest_checker.sv */
//------------------------------------------------------------------------------
// Flow EWMA statistics table checker
// Port-level properties of the statistics table.
//------------------------------------------------------------------------------
module fest_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input fest_pkg::res_t result
);
	import fest_pkg::*;

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request taken without going busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a request in flight");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.accepted) |-> (result.rate_average == '0
		&& result.blocking_average == '0 && result.delay_average_us == '0))
		else $error("rejected request with nonzero result");
	a_blk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.blocking_average <= ALPHA_ONE))
		else $error("blocking average above one");
endmodule

bind flow_ewma_statistics_table fest_checker u_fest_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .result(result));
